@@ hdl/pn2d_pkg.sv @@
`default_nettype none
package pn2d_pkg;

   localparam int unsigned DEF_GRID_SIZE  = 256;
   localparam int unsigned DEF_FRAC_BITS  = 12;
   localparam int unsigned DEF_COORD_BITS = 24;

   localparam int unsigned Q16_SHIFT = 16;
   localparam int unsigned ONE_Q16   = 65536;
   localparam int unsigned NUM_BANKS = 4;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   // Command word: is_eval, wbank(2), waddr, wcode(2), 4 read addresses,
   // x0/y0 parity, dx(16), dy(16).
   function automatic int unsigned cmd_width(input int unsigned addr_bits);
      return 39 + 5 * addr_bits;
   endfunction

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

@@ hdl/pn2d_front.sv @@
`default_nettype none
module pn2d_front
   import pn2d_pkg::*;
#(
   parameter int unsigned GRID_SIZE  = DEF_GRID_SIZE,
   parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS,
   parameter int unsigned COORD_BITS = DEF_COORD_BITS,
   parameter int unsigned CMD_W      = cmd_width(2 * ($clog2(DEF_GRID_SIZE) - 1))
) (
   input  wire logic                         func,
   input  wire logic [7:0]                   grid_row,
   input  wire logic [7:0]                   grid_col,
   input  wire logic [1:0]                   gradient_code,
   input  wire logic signed [COORD_BITS-1:0] coord_x,
   input  wire logic signed [COORD_BITS-1:0] coord_y,
   output logic [CMD_W-1:0]                  cmd
);

   localparam int unsigned GB = $clog2(GRID_SIZE);
   localparam int unsigned AB = 2 * (GB - 1);
   localparam int unsigned XW = COORD_BITS + GB;

   typedef struct packed {
      logic                 is_eval;
      logic [1:0]           wbank;
      logic [AB-1:0]        waddr;
      logic [1:0]           wcode;
      logic [3:0][AB-1:0]   raddr;
      logic                 x0p;
      logic                 y0p;
      logic [15:0]          dx;
      logic [15:0]          dy;
   } cmd_type;

   cmd_type             c;
   logic [GB-1:0]       row, col, x0, x1, y0, y1, rsel, csel;
   logic signed [XW-1:0] xe, ye;

   always_comb begin
      row = GB'(grid_row);
      col = GB'(grid_col);
      // floor division by the fraction scale, then wrap to the grid
      xe = XW'(coord_x) >>> FRAC_BITS;
      ye = XW'(coord_y) >>> FRAC_BITS;
      x0 = xe[GB-1:0];
      y0 = ye[GB-1:0];
      x1 = x0 + GB'(1);
      y1 = y0 + GB'(1);

      c.is_eval = (func == FUNC_EVAL);
      c.wbank   = {row[0], col[0]};
      c.waddr   = {row[GB-1:1], col[GB-1:1]};
      c.wcode   = gradient_code;
      rsel = '0;
      csel = '0;
      for (int b = 0; b < 4; b++) begin
         rsel = (y0[0] == b[1]) ? y0 : y1;
         csel = (x0[0] == b[0]) ? x0 : x1;
         c.raddr[b] = {rsel[GB-1:1], csel[GB-1:1]};
      end
      c.x0p = x0[0];
      c.y0p = y0[0];
      c.dx  = 16'(coord_x[FRAC_BITS-1:0]) << (Q16_SHIFT - FRAC_BITS);
      c.dy  = 16'(coord_y[FRAC_BITS-1:0]) << (Q16_SHIFT - FRAC_BITS);
      cmd = c;
   end

endmodule
`default_nettype wire

@@ hdl/pn2d_queue.sv @@
`default_nettype none
module pn2d_queue
   import pn2d_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head,
   output queue_status_type      status
);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      status.full  = (count_ff == 2'(QUEUE_DEPTH));
      status.empty = (count_ff == 2'd0);
      head = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

@@ hdl/pn2d_back.sv @@
`default_nettype none
module pn2d_back
   import pn2d_pkg::*;
#(
   parameter int unsigned GRID_SIZE = DEF_GRID_SIZE,
   parameter int unsigned CMD_W     = cmd_width(2 * ($clog2(DEF_GRID_SIZE) - 1))
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CMD_W-1:0] cmd,
   input  wire logic             cmd_avail,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [15:0]           rsp_noise
);

   localparam int unsigned GB = $clog2(GRID_SIZE);
   localparam int unsigned AB = 2 * (GB - 1);
   localparam int unsigned BANK_DEPTH = 1 << AB;

   typedef struct packed {
      logic                 is_eval;
      logic [1:0]           wbank;
      logic [AB-1:0]        waddr;
      logic [1:0]           wcode;
      logic [3:0][AB-1:0]   raddr;
      logic                 x0p;
      logic                 y0p;
      logic [15:0]          dx;
      logic [15:0]          dy;
   } cmd_type;

   cmd_type c;
   logic    en;

   logic [1:0] bank_mem [NUM_BANKS][BANK_DEPTH];

   // stage valids
   logic [6:0] v_ff;

   // stage 1
   logic [3:0][1:0] rd_ff;
   logic            x0p_ff, y0p_ff;
   logic [15:0]     dx1_ff, dy1_ff;
   logic [31:0]     tx2p_ff, ty2p_ff;
   // stage 2
   logic signed [17:0] d00_ff, d01_ff, d10_ff, d11_ff;
   logic [31:0]        tx3p_ff, ty3p_ff;
   logic [19:0]        px_ff, py_ff;
   // stage 3
   logic signed [17:0] d00_3_ff, d01_3_ff, d10_3_ff, d11_3_ff;
   logic [35:0]        fxp_ff, fyp_ff;
   // stage 4
   logic signed [17:0] d00_4_ff, d01_4_ff;
   logic signed [39:0] l0p_ff, l1p_ff;
   logic signed [20:0] fy4_ff;
   // stage 5
   logic signed [23:0] e0_ff, e1_ff;
   logic signed [20:0] fy5_ff;
   // stage 6
   logic signed [23:0] e0_6_ff;
   logic signed [45:0] l2p_ff;
   // stage 7
   logic [15:0]        noise_ff;

   // combinational helpers
   logic [15:0]        t2x, t2y, t3x, t3y;
   logic [21:0]        pax, pbx, pay, pby;
   logic [3:0][1:0]    code;
   logic signed [17:0] oxa, oxb, oya, oyb;
   logic signed [20:0] fx4, fy4;
   logic signed [18:0] diff0, diff1;
   logic signed [24:0] diff2;
   logic signed [29:0] v, s;
   logic signed [28:0] sh;
   logic [15:0]        noise_in;

   function automatic logic signed [17:0] dot(input logic [1:0] g,
                                               input logic signed [17:0] ox,
                                               input logic signed [17:0] oy);
      logic signed [17:0] a, b;
      a = g[1] ? ox : -ox;
      b = g[0] ? oy : -oy;
      return a + b;
   endfunction

   assign c         = cmd;
   assign en        = ~v_ff[6] | ~rsp_stall;
   assign cmd_pop   = en & cmd_avail;
   assign rsp_valid = v_ff[6];
   assign rsp_noise = noise_ff;

   always_comb begin
      // fade: t2, t3, polynomial
      t2x = tx2p_ff[31:16];
      t2y = ty2p_ff[31:16];
      pax = 22'(t2x) * 22'd6 + 22'(10 * ONE_Q16);
      pbx = 22'(dx1_ff) * 22'd15;
      pay = 22'(t2y) * 22'd6 + 22'(10 * ONE_Q16);
      pby = 22'(dy1_ff) * 22'd15;
      t3x = tx3p_ff[31:16];
      t3y = ty3p_ff[31:16];

      // corner codes by bank parity
      code[0] = rd_ff[{y0p_ff,  x0p_ff}];
      code[1] = rd_ff[{~y0p_ff, x0p_ff}];
      code[2] = rd_ff[{y0p_ff,  ~x0p_ff}];
      code[3] = rd_ff[{~y0p_ff, ~x0p_ff}];
      oxa = 18'(dx1_ff);
      oxb = oxa - 18'sd65536;
      oya = 18'(dy1_ff);
      oyb = oya - 18'sd65536;

      fx4   = $signed({1'b0, fxp_ff[35:16]});
      fy4   = $signed({1'b0, fyp_ff[35:16]});
      diff0 = 19'(d10_3_ff) - 19'(d00_3_ff);
      diff1 = 19'(d11_3_ff) - 19'(d01_3_ff);
      diff2 = 25'(e1_ff) - 25'(e0_ff);

      v  = 30'(e0_6_ff) + 30'(l2p_ff[45:16]);
      s  = v + 30'sd65536;
      sh = s[29:1];
      if (s < 0)
         noise_in = 16'd0;
      else if (sh > 29'sd65535)
         noise_in = 16'hFFFF;
      else
         noise_in = sh[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], cmd_pop & c.is_eval};
      end

      for (int b = 0; b < NUM_BANKS; b++) begin
         if (cmd_pop && !c.is_eval && c.wbank == 2'(b))
            bank_mem[b][c.waddr] <= c.wcode;
      end

      if (en) begin
         for (int b = 0; b < NUM_BANKS; b++)
            rd_ff[b] <= bank_mem[b][c.raddr[b]];
         x0p_ff  <= c.x0p;
         y0p_ff  <= c.y0p;
         dx1_ff  <= c.dx;
         dy1_ff  <= c.dy;
         tx2p_ff <= 32'(c.dx) * 32'(c.dx);
         ty2p_ff <= 32'(c.dy) * 32'(c.dy);

         d00_ff  <= dot(code[0], oxa, oya);
         d01_ff  <= dot(code[1], oxa, oyb);
         d10_ff  <= dot(code[2], oxb, oya);
         d11_ff  <= dot(code[3], oxb, oyb);
         tx3p_ff <= 32'(t2x) * 32'(dx1_ff);
         ty3p_ff <= 32'(t2y) * 32'(dy1_ff);
         px_ff   <= (pax >= pbx) ? 20'(pax - pbx) : 20'd0;
         py_ff   <= (pay >= pby) ? 20'(pay - pby) : 20'd0;

         d00_3_ff <= d00_ff;
         d01_3_ff <= d01_ff;
         d10_3_ff <= d10_ff;
         d11_3_ff <= d11_ff;
         fxp_ff   <= 36'(t3x) * 36'(px_ff);
         fyp_ff   <= 36'(t3y) * 36'(py_ff);

         d00_4_ff <= d00_3_ff;
         d01_4_ff <= d01_3_ff;
         l0p_ff   <= 40'(diff0) * 40'(fx4);
         l1p_ff   <= 40'(diff1) * 40'(fx4);
         fy4_ff   <= fy4;

         // arithmetic shift of the product is the floor
         e0_ff  <= 24'(d00_4_ff) + l0p_ff[39:16];
         e1_ff  <= 24'(d01_4_ff) + l1p_ff[39:16];
         fy5_ff <= fy4_ff;

         e0_6_ff <= e0_ff;
         l2p_ff  <= 46'(diff2) * 46'(fy5_ff);

         noise_ff <= noise_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/perlin_noise_2d_top.sv @@
// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_stall | func, grid_row, grid_col, gradient_code,
//          |           |                     | coord_x, coord_y
// rsp      | out       | rsp_valid/rsp_stall | noise (evaluate transactions only)
//
// One transaction per cycle sustained while rsp is not stalled; an evaluate result is registered
// after its req transaction is accepted, passing through the two-entry queue and then the back
// pipeline stages set by the fade and blend multiplier chain.
// Four gradient banks split by row and column parity give all four corners in one read.
// Reset clears control only; the gradient table holds garbage until loaded.
// A stalled rsp freezes the whole back pipeline; req stalls only when the queue is full.
`default_nettype none
module perlin_noise_2d_top
   import pn2d_pkg::*;
#(
   parameter int unsigned GRID_SIZE  = DEF_GRID_SIZE,
   parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS,
   parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_func,
   input  wire logic [7:0]                   req_grid_row,
   input  wire logic [7:0]                   req_grid_col,
   input  wire logic [1:0]                   req_gradient_code,
   input  wire logic signed [COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [15:0]                       rsp_noise
);

   localparam int unsigned CMD_W = cmd_width(2 * ($clog2(GRID_SIZE) - 1));

   logic [CMD_W-1:0] front_cmd, queue_head;
   queue_status_type q_status;
   logic             push, pop;

   assign req_stall = q_status.full;
   assign push      = req_valid & ~q_status.full;

   pn2d_front #(
      .GRID_SIZE(GRID_SIZE), .FRAC_BITS(FRAC_BITS),
      .COORD_BITS(COORD_BITS), .CMD_W(CMD_W)
   ) u_front (
      .func(req_func), .grid_row(req_grid_row), .grid_col(req_grid_col),
      .gradient_code(req_gradient_code), .coord_x(req_coord_x),
      .coord_y(req_coord_y), .cmd(front_cmd)
   );

   pn2d_queue #(.WIDTH(CMD_W)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(front_cmd),
      .pop(pop), .head(queue_head), .status(q_status)
   );

   pn2d_back #(.GRID_SIZE(GRID_SIZE), .CMD_W(CMD_W)) u_back (
      .clock(clock), .reset(reset), .cmd(queue_head), .cmd_avail(~q_status.empty),
      .cmd_pop(pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise(rsp_noise)
   );

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty)) else $error("queue full and empty");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty) else $error("pop from empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise))
      else $error("stalled result changed");

endmodule
`default_nettype wire

@@ verif/perlin_noise_2d_top_tb.sv @@
`default_nettype none
module perlin_noise_2d_top_tb;
   import pn2d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID   = DEF_GRID_SIZE;
   localparam int FRAC   = DEF_FRAC_BITS;
   localparam int CBITS  = DEF_COORD_BITS;
   localparam int RAND_ITEMS = 380;
   localparam longint CYCLE_LIMIT = 400000;

   // Predicts noise samples from its own copy of the gradient grid and holds
   // the samples still owed by the block.
   class noise_scoreboard;
      bit [1:0]    grad_grid [GRID*GRID];
      bit [15:0]   pending_noise [$];
      int          mismatches;
      int          loads_seen;
      int          evals_seen;

      function automatic longint floor_div2p(longint v, int s);
         return v >>> s;
      endfunction

      function automatic longint fade(longint t);
         longint t2, t3, p;
         t2 = (t * t) >>> 16;
         t3 = (t2 * t) >>> 16;
         p = 6 * t2 + 10 * longint'(ONE_Q16) - 15 * t;
         if (p < 0) p = 0;
         return (t3 * p) >>> 16;
      endfunction

      function automatic longint blend(longint a, longint b, longint f);
         return a + floor_div2p((b - a) * f, 16);
      endfunction

      function automatic longint corner(int row, int col, longint ox, longint oy);
         bit [1:0] code;
         code = grad_grid[row * GRID + col];
         return (code[1] ? ox : -ox) + (code[0] ? oy : -oy);
      endfunction

      function automatic void note_request(logic func, logic [7:0] row, logic [7:0] col,
                                           logic [1:0] code, logic signed [CBITS-1:0] x,
                                           logic signed [CBITS-1:0] y);
         longint cx, cy, dx, dy, fx, fy, e0, e1, v, s;
         int x0, x1, y0, y1;
         if (func == FUNC_LOAD) begin
            grad_grid[(row % GRID) * GRID + (col % GRID)] = code;
            loads_seen++;
            return;
         end
         evals_seen++;
         cx = floor_div2p(longint'(x), FRAC);
         cy = floor_div2p(longint'(y), FRAC);
         dx = longint'(x[FRAC-1:0]) << (16 - FRAC);
         dy = longint'(y[FRAC-1:0]) << (16 - FRAC);
         x0 = ((cx % GRID) + GRID) % GRID;
         x1 = (x0 + 1) % GRID;
         y0 = ((cy % GRID) + GRID) % GRID;
         y1 = (y0 + 1) % GRID;
         fx = fade(dx);
         fy = fade(dy);
         e0 = blend(corner(y0, x0, dx, dy), corner(y0, x1, dx - ONE_Q16, dy), fx);
         e1 = blend(corner(y1, x0, dx, dy - ONE_Q16),
                    corner(y1, x1, dx - ONE_Q16, dy - ONE_Q16), fx);
         v = blend(e0, e1, fy);
         s = v + ONE_Q16;
         if (s < 0) s = 0;
         s = s >>> 1;
         if (s > 65535) s = 65535;
         pending_noise.push_back(s[15:0]);
      endfunction

      function automatic void check_noise(logic [15:0] got);
         bit [15:0] want;
         if (pending_noise.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected noise transaction %h", got);
            return;
         end
         want = pending_noise.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: noise expected %h got %h", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = FUNC_LOAD;
   logic [7:0] req_grid_row = '0;
   logic [7:0] req_grid_col = '0;
   logic [1:0] req_gradient_code = '0;
   logic signed [CBITS-1:0] req_coord_x = '0;
   logic signed [CBITS-1:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_noise;

   noise_scoreboard sb = new();
   longint cycles = 0;
   bit stall_quiet = 1'b0;

   perlin_noise_2d_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_func, req_grid_row, req_grid_col, req_gradient_code,
                            req_coord_x, req_coord_y);
         if (rsp_valid && !rsp_stall)
            sb.check_noise(rsp_noise);
      end
   end

   // Stall in phases: quiet stretches, light stalling and heavy stalling.
   always @(negedge clock) begin
      int phase;
      phase = (cycles / 300) % 3;
      if (reset || stall_quiet || phase == 0)
         rsp_stall <= 1'b0;
      else if (phase == 1)
         rsp_stall <= ($urandom_range(0, 7) == 0);
      else
         rsp_stall <= ($urandom_range(0, 2) != 0);
   end

   int burst_left = 0;

   // Present one transaction, hold it until accepted, then insert any burst gap.
   task automatic send(logic func, logic [7:0] row, logic [7:0] col, logic [1:0] code,
                       logic signed [CBITS-1:0] x, logic signed [CBITS-1:0] y);
      req_valid <= 1'b1;
      req_func <= func;
      req_grid_row <= row;
      req_grid_col <= col;
      req_gradient_code <= code;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   task automatic load(int row, int col, logic [1:0] code);
      send(FUNC_LOAD, row[7:0], col[7:0], code, CBITS'($urandom), CBITS'($urandom));
   endtask

   task automatic eval(logic signed [CBITS-1:0] x, logic signed [CBITS-1:0] y);
      send(FUNC_EVAL, 8'($urandom), 8'($urandom), 2'($urandom), x, y);
   endtask

   // Load a 16 x 16 window around the grid origin; every evaluation keeps its
   // four corners inside it.
   task automatic fill_grid;
      for (int r = -8; r < 8; r++)
         for (int c = -8; c < 8; c++)
            load((r + GRID) % GRID, (c + GRID) % GRID, 2'($urandom));
   endtask

   function automatic logic signed [CBITS-1:0] rand_coord;
      case ($urandom_range(0, 4))
         0: return CBITS'((int'($urandom_range(0, 14)) - 7) * (GRID << FRAC)
                          + int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
         1: return CBITS'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
         2: return {1'b0, {(CBITS-1){1'b1}}} - CBITS'($urandom_range(0, 1 << FRAC));
         3: return {1'b1, {(CBITS-1){1'b0}}} + CBITS'($urandom_range(0, 1 << FRAC));
         default: return CBITS'($signed(GRID << FRAC)) + CBITS'($urandom_range(0, 1 << FRAC))
                         - CBITS'(1 << FRAC);
      endcase
   endfunction

   initial begin
      localparam logic signed [CBITS-1:0] MAXC = {1'b0, {(CBITS-1){1'b1}}};
      localparam logic signed [CBITS-1:0] MINC = {1'b1, {(CBITS-1){1'b0}}};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      stall_quiet = 1'b1;
      fill_grid();
      stall_quiet = 1'b0;
      // Corner coordinates, wrap at both grid ends, saturation-prone points.
      eval('0, '0);
      eval(MAXC, MAXC);
      eval(MINC, MINC);
      eval(MAXC, MINC);
      eval(CBITS'(-1), CBITS'(-1));
      eval(CBITS'(1 << (FRAC - 1)), CBITS'(1 << (FRAC - 1)));
      eval(CBITS'((GRID << FRAC) - 1), CBITS'((GRID << FRAC) - 1));
      eval(CBITS'(-(1 << FRAC)), CBITS'(1 << FRAC));
      load(0, 0, 2'd3); load(0, 1, 2'd2); load(1, 0, 2'd1); load(1, 1, 2'd0);
      eval(CBITS'(1 << (FRAC - 1)), CBITS'(1 << (FRAC - 1)));
      load(0, 0, 2'd3); load(0, 1, 2'd3); load(1, 0, 2'd3); load(1, 1, 2'd3);
      eval(CBITS'(3 << (FRAC - 2)), CBITS'(3 << (FRAC - 2)));
      load(0, 0, 2'd0); load(0, 1, 2'd0); load(1, 0, 2'd0); load(1, 1, 2'd0);
      eval(CBITS'(1 << (FRAC - 2)), CBITS'(1 << (FRAC - 2)));
      eval(CBITS'(GRID << FRAC), CBITS'(-(GRID << FRAC)));
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if ($urandom_range(0, 4) == 0)
            load($urandom_range(0, 255), $urandom_range(0, 255), 2'($urandom));
         else
            eval(rand_coord(), rand_coord());
      end
      req_valid <= 1'b0;
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Loaded %0d gradient entries and evaluated %0d noise samples.",
               sb.loads_seen, sb.evals_seen);
      $display("Coordinates covered both extremes, grid wrap, and saturation paths.");
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
hdl/pn2d_pkg.sv
hdl/pn2d_front.sv
hdl/pn2d_queue.sv
hdl/pn2d_back.sv
hdl/perlin_noise_2d_top.sv
verif/perlin_noise_2d_top_tb.sv
